@@ rtl/core/bfv_pkg.sv @@
// Shared types, widths and register codes for the box frustum visibility test.
package bfv_pkg;

    // Coordinate and plane coefficient formats
    localparam int COORD_W     = 24;
    localparam int COEF_W      = 12;
    localparam int OFFS_W      = 28;
    localparam int PROD_W      = COORD_W + COEF_W;
    localparam int OFFS_SHIFT  = 10;
    localparam int SUM_W       = 39;
    localparam int PLANE_W     = 64;
    localparam int PLANE_COUNT = 6;

    // Field positions inside one packed plane word
    localparam int A_LSB = 52;
    localparam int B_LSB = 40;
    localparam int C_LSB = 28;

    // Configuration port geometry: one 64-bit register every 8 bytes
    localparam int ADDR_W      = 6;
    localparam int CFG_IDX_LSB = 3;
    localparam int CFG_IDX_W   = ADDR_W - CFG_IDX_LSB;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LEFT   = 3'd0,
        REG_RIGHT  = 3'd1,
        REG_BOTTOM = 3'd2,
        REG_TOP    = 3'd3,
        REG_NEAR   = 3'd4,
        REG_FAR    = 3'd5
    } t_reg_idx;

    typedef logic [PLANE_COUNT-1:0][PLANE_W-1:0] t_plane_set;

    typedef struct packed {
        logic signed [COORD_W-1:0] min_x;
        logic signed [COORD_W-1:0] min_y;
        logic signed [COORD_W-1:0] min_z;
        logic signed [COORD_W-1:0] max_x;
        logic signed [COORD_W-1:0] max_y;
        logic signed [COORD_W-1:0] max_z;
    } t_box;

    // Load enables for the plane evaluation stages
    typedef struct packed {
        logic load2;
        logic load3;
    } t_pipe_en;

endpackage

@@ rtl/core/bfv_cfg_regs.sv @@
// APB register file holding the six packed frustum planes.
module bfv_cfg_regs import bfv_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [PLANE_W-1:0]  pwdata,
    output logic [PLANE_W-1:0]  prdata,
    output logic                pready,
    output t_plane_set          o_planes
);

    logic [PLANE_COUNT-1:0][PLANE_W-1:0] r_planes;
    logic [CFG_IDX_W-1:0]                w_idx;
    logic                                w_idx_ok;
    logic                                w_wr;

    // Decode register index; the top two codes are unused
    assign w_idx    = paddr[ADDR_W-1:CFG_IDX_LSB];
    assign w_idx_ok = (w_idx <= REG_FAR);
    assign w_wr     = psel && penable && pwrite;
    assign pready   = 1'b1;

    // Write on the access phase of a beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_planes <= '0;
        end else if (w_wr && w_idx_ok) begin
            r_planes[w_idx] <= pwdata;
        end
    end

    // Read back; unused indexes return zero
    assign prdata   = w_idx_ok ? r_planes[w_idx] : '0;
    assign o_planes = r_planes;

endmodule

@@ rtl/core/bfv_plane_eval.sv @@
// One plane: positive-vertex selection, products, and the registered sign test.
module bfv_plane_eval import bfv_pkg::*; (
    input  logic                i_clk,
    input  logic [PLANE_W-1:0]  i_plane,
    input  t_box                i_box,
    input  t_pipe_en            i_en,
    output logic                o_behind
);

    logic signed [COEF_W-1:0]  w_a, w_b, w_c;
    logic signed [OFFS_W-1:0]  w_d;
    logic signed [COORD_W-1:0] w_px, w_py, w_pz;
    logic signed [PROD_W-1:0]  n_prod_x, n_prod_y, n_prod_z;
    logic signed [PROD_W-1:0]  r_prod_x, r_prod_y, r_prod_z;
    logic signed [OFFS_W-1:0]  r_d;
    logic                      r_skip;
    logic signed [SUM_W-1:0]   w_sum;
    logic                      r_behind;

    // Unpack coefficients
    assign w_a = i_plane[A_LSB +: COEF_W];
    assign w_b = i_plane[B_LSB +: COEF_W];
    assign w_c = i_plane[C_LSB +: COEF_W];
    assign w_d = i_plane[OFFS_W-1:0];

    // Pick the corner farthest along the normal
    assign w_px = w_a[COEF_W-1] ? i_box.min_x : i_box.max_x;
    assign w_py = w_b[COEF_W-1] ? i_box.min_y : i_box.max_y;
    assign w_pz = w_c[COEF_W-1] ? i_box.min_z : i_box.max_z;

    // Exact products, each fits the full product width
    assign n_prod_x = PROD_W'(w_a) * PROD_W'(w_px);
    assign n_prod_y = PROD_W'(w_b) * PROD_W'(w_py);
    assign n_prod_z = PROD_W'(w_c) * PROD_W'(w_pz);

    // Stage 2: hold products, offset and the skip flag
    always_ff @(posedge i_clk) begin
        if (i_en.load2) begin
            r_prod_x <= n_prod_x;
            r_prod_y <= n_prod_y;
            r_prod_z <= n_prod_z;
            r_d      <= w_d;
            r_skip   <= (w_a == '0) && (w_b == '0) && (w_c == '0);
        end
    end

    // Signed distance with the offset aligned to the product fraction
    assign w_sum = SUM_W'(r_prod_x) + SUM_W'(r_prod_y) + SUM_W'(r_prod_z)
                 + (SUM_W'(r_d) <<< OFFS_SHIFT);

    // Stage 3: box lies wholly behind a non-degenerate plane
    always_ff @(posedge i_clk) begin
        if (i_en.load3) begin
            r_behind <= w_sum[SUM_W-1] && !r_skip;
        end
    end

    assign o_behind = r_behind;

endmodule

@@ rtl/core/box_frustum_visibility_test.sv @@
// Top level: APB plane registers and a four-stage box culling pipeline.
// Throughput: one box per cycle; stages capture, multiply, sum and combine.
// Each stage holds its beat under back-pressure and bubbles close up.
// Synchronous active-low reset empties the pipeline and clears all planes to zero.
module box_frustum_visibility_test import bfv_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [ADDR_W-1:0]          paddr,
    input  logic [PLANE_W-1:0]         pwdata,
    output logic [PLANE_W-1:0]         prdata,
    output logic                       pready,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic signed [COORD_W-1:0]  i_box_min_x,
    input  logic signed [COORD_W-1:0]  i_box_min_y,
    input  logic signed [COORD_W-1:0]  i_box_min_z,
    input  logic signed [COORD_W-1:0]  i_box_max_x,
    input  logic signed [COORD_W-1:0]  i_box_max_y,
    input  logic signed [COORD_W-1:0]  i_box_max_z,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic                       o_visible
);

    t_plane_set             w_planes;
    t_box                   r_box;
    t_pipe_en               w_en;
    logic [PLANE_COUNT-1:0] w_behind;
    logic                   r_v1, r_v2, r_v3, r_v4;
    logic                   r_ok1, r_ok2, r_ok3;
    logic                   r_visible;
    logic                   w_free1, w_free2, w_free3, w_free4;
    logic                   n_ok;

    bfv_cfg_regs u_cfg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .o_planes (w_planes)
    );

    // A stage loads when it is empty or its beat moves on
    assign w_free4    = !r_v4 || i_out_ready;
    assign w_free3    = !r_v3 || w_free4;
    assign w_free2    = !r_v2 || w_free3;
    assign w_free1    = !r_v1 || w_free2;
    assign o_in_ready = w_free1;
    assign w_en.load2 = w_free2;
    assign w_en.load3 = w_free3;

    // Box is valid when no axis is inverted
    assign n_ok = (i_box_min_x <= i_box_max_x) && (i_box_min_y <= i_box_max_y)
               && (i_box_min_z <= i_box_max_z);

    // Advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (w_free1) r_v1 <= i_in_valid;
            if (w_free2) r_v2 <= r_v1;
            if (w_free3) r_v3 <= r_v2;
            if (w_free4) r_v4 <= r_v3;
        end
    end

    // Stage 1: capture the box beat
    always_ff @(posedge i_clk) begin
        if (w_free1) begin
            r_box.min_x <= i_box_min_x;
            r_box.min_y <= i_box_min_y;
            r_box.min_z <= i_box_min_z;
            r_box.max_x <= i_box_max_x;
            r_box.max_y <= i_box_max_y;
            r_box.max_z <= i_box_max_z;
            r_ok1       <= n_ok;
        end
    end

    // Stages 2 and 3: per-plane evaluation
    for (genvar g = 0; g < PLANE_COUNT; g++) begin : g_plane
        bfv_plane_eval u_eval (
            .i_clk    (i_clk),
            .i_plane  (w_planes[g]),
            .i_box    (r_box),
            .i_en     (w_en),
            .o_behind (w_behind[g])
        );
    end

    // Carry the box validity alongside, then combine into the output register
    always_ff @(posedge i_clk) begin
        if (w_free2) r_ok2 <= r_ok1;
        if (w_free3) r_ok3 <= r_ok2;
        if (w_free4) r_visible <= r_ok3 && !(|w_behind);
    end

    assign o_out_valid = r_v4;
    assign o_visible   = r_visible;

endmodule

@@ rtl/core/bfv_checker.sv @@
// Port-level checker for the box frustum visibility test, bound to the top level.
module bfv_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic o_in_ready,
    input logic o_out_valid,
    input logic i_out_ready,
    input logic o_visible
);

    // Hold a stalled result beat
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_visible))
        else $error("result beat dropped or changed while stalled");

    // Reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result beat present after reset");

    // An open output leaves the input open
    a_ready_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_ready |-> o_in_ready)
        else $error("input stalled while output is free");

    // An accepted beat reaches the output while the output stays ready
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_out_ready ##1 i_out_ready
         ##1 i_out_ready ##1 i_out_ready) |=> o_out_valid)
        else $error("result beat missing after pipeline latency");

endmodule

bind box_frustum_visibility_test bfv_checker u_bfv_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_visible   (o_visible)
);

@@ verif/bfv_visibility_checker.sv @@
// Checker for the box frustum visibility test: shadows the planes, predicts and compares.
module bfv_visibility_checker import bfv_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_psel,
    input  logic               i_penable,
    input  logic               i_pwrite,
    input  logic               i_pready,
    input  logic [ADDR_W-1:0]  i_paddr,
    input  logic [PLANE_W-1:0] i_pwdata,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  t_box               i_box,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  logic               i_visible,
    output int                 o_mismatches,
    output int                 o_outstanding,
    output int                 o_visible_beats
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [PLANE_W-1:0] plane_copy [PLANE_COUNT];
    logic               visible_due [$];
    logic               visible_want;
    int unsigned        plane_idx;

    task automatic flag_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $time, msg);
        o_mismatches = o_mismatches + 1;
    endtask

    // Positive-vertex test of one box against the shadowed planes
    function automatic logic box_visible(input t_box b);
        logic signed [COEF_W-1:0] na;
        logic signed [COEF_W-1:0] nb;
        logic signed [COEF_W-1:0] nc;
        logic signed [OFFS_W-1:0] offs;
        longint                   lo [3];
        longint                   hi [3];
        longint                   reach;
        logic                     vis;
        lo[0] = longint'($signed(b.min_x));
        lo[1] = longint'($signed(b.min_y));
        lo[2] = longint'($signed(b.min_z));
        hi[0] = longint'($signed(b.max_x));
        hi[1] = longint'($signed(b.max_y));
        hi[2] = longint'($signed(b.max_z));
        vis = 1'b1;
        // an inverted axis rules the box out before any plane is looked at
        for (int k = 0; k < 3; k++) begin
            if (lo[k] > hi[k]) begin
                vis = 1'b0;
            end
        end
        for (int p = 0; p < PLANE_COUNT; p++) begin
            {na, nb, nc, offs} = plane_copy[p];
            // a plane with no normal never culls, whatever its offset
            if (vis && (na != 0 || nb != 0 || nc != 0)) begin
                reach = longint'(na) * (na >= 0 ? hi[0] : lo[0])
                      + longint'(nb) * (nb >= 0 ? hi[1] : lo[1])
                      + longint'(nc) * (nc >= 0 ? hi[2] : lo[2])
                      + (longint'(offs) <<< OFFS_SHIFT);
                if (reach < 0) begin
                    vis = 1'b0;
                end
            end
        end
        return vis;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int p = 0; p < PLANE_COUNT; p++) begin
                plane_copy[p] = '0;
            end
            visible_due.delete();
            o_outstanding   <= 0;
            o_visible_beats <= 0;
        end else begin
            // shadow plane writes; indexes past the last plane are dropped
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                plane_idx = i_paddr[CFG_IDX_LSB +: CFG_IDX_W];
                if (plane_idx < PLANE_COUNT) begin
                    plane_copy[plane_idx] = i_pwdata;
                end
            end
            // predict on every accepted input beat
            if (i_in_valid && i_in_ready) begin
                visible_due.push_back(box_visible(i_box));
            end
            // compare every accepted result beat with the oldest prediction
            if (i_out_valid && i_out_ready) begin
                if (visible_due.size() == 0) begin
                    flag_mismatch($sformatf("result beat visible=%0b with nothing expected",
                                            i_visible));
                end else begin
                    visible_want = visible_due.pop_front();
                    if (i_visible !== visible_want) begin
                        flag_mismatch($sformatf("visible=%0b, expected %0b",
                                                i_visible, visible_want));
                    end
                    if (i_visible === 1'b1) begin
                        o_visible_beats <= o_visible_beats + 1;
                    end
                end
            end
            o_outstanding <= visible_due.size();
        end
    end

endmodule

@@ verif/tb_box_frustum_visibility_test.sv @@
// Testbench top for the box frustum visibility test: clock, reset, stimulus and verdict.
module tb_box_frustum_visibility_test import bfv_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int COORD_MIN    = -(1 << (COORD_W - 1));
    localparam int COORD_MAX    = (1 << (COORD_W - 1)) - 1;
    localparam int COEF_MIN     = -(1 << (COEF_W - 1));
    localparam int COEF_MAX     = (1 << (COEF_W - 1)) - 1;
    localparam int OFFS_MIN     = -(1 << (OFFS_W - 1));
    localparam int OFFS_MAX     = (1 << (OFFS_W - 1)) - 1;
    localparam int ONE_Q10      = 1 << OFFS_SHIFT;
    localparam int ONE_Q8       = 1 << 8;
    localparam int IDLE_MAX     = 11;
    localparam int HOLD_CYCLES  = 300;
    localparam int SETTLE_TAIL  = 8;
    localparam int RAND_PHASES  = 10;
    localparam int PHASE_BOXES  = 183;
    localparam int TIMEOUT_NS   = 5_000_000;

    typedef enum int {SET_RAW, SET_FRUSTUM, SET_SPARSE, SET_EXTREME} t_plane_mix;

    localparam int COEF_PICK [5] = '{COEF_MIN, COEF_MAX, 0, -1, 1};
    localparam int OFFS_PICK [4] = '{OFFS_MIN, OFFS_MAX, 0, -1};

    logic               i_clk;
    logic               i_rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [ADDR_W-1:0]  paddr;
    logic [PLANE_W-1:0] pwdata;
    logic [PLANE_W-1:0] cfg_rdata;
    logic               pready;
    logic               i_in_valid;
    logic               o_in_ready;
    t_box               box_drv;
    logic               o_out_valid;
    logic               i_out_ready;
    logic               o_visible;

    int         mismatches;
    int         outstanding;
    int         visible_beats;
    int         tx_idle_max;
    int         rx_idle_max;
    int         rx_gap;
    bit         hold_req;
    int         boxes_sent;
    int         directed_sent;
    int         plane_sets;
    t_plane_set plane_set;

    box_frustum_visibility_test dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (cfg_rdata),
        .pready      (pready),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_box_min_x (box_drv.min_x),
        .i_box_min_y (box_drv.min_y),
        .i_box_min_z (box_drv.min_z),
        .i_box_max_x (box_drv.max_x),
        .i_box_max_y (box_drv.max_y),
        .i_box_max_z (box_drv.max_z),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_visible   (o_visible)
    );

    bfv_visibility_checker checker_i (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_psel          (psel),
        .i_penable       (penable),
        .i_pwrite        (pwrite),
        .i_pready        (pready),
        .i_paddr         (paddr),
        .i_pwdata        (pwdata),
        .i_in_valid      (i_in_valid),
        .i_in_ready      (o_in_ready),
        .i_box           (box_drv),
        .i_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .i_visible       (o_visible),
        .o_mismatches    (mismatches),
        .o_outstanding   (outstanding),
        .o_visible_beats (visible_beats)
    );

    function automatic logic [PLANE_W-1:0] pack_plane(input int a, input int b, input int c,
                                                     input int d);
        return {COEF_W'(a), COEF_W'(b), COEF_W'(c), OFFS_W'(d)};
    endfunction

    function automatic t_box mk_box(input int x0, input int y0, input int z0,
                                    input int x1, input int y1, input int z1);
        t_box b;
        b.min_x = COORD_W'(x0);
        b.min_y = COORD_W'(y0);
        b.min_z = COORD_W'(z0);
        b.max_x = COORD_W'(x1);
        b.max_y = COORD_W'(y1);
        b.max_z = COORD_W'(z1);
        return b;
    endfunction

    function automatic int clamp_coord(input longint v);
        if (v > COORD_MAX) begin
            return COORD_MAX;
        end
        if (v < COORD_MIN) begin
            return COORD_MIN;
        end
        return int'(v);
    endfunction

    // Mostly ordered boxes of random scale; some raw ones, which are often inverted
    function automatic t_box rand_box();
        int     kind;
        int     sc;
        longint centre;
        longint span;
        longint lo [3];
        longint hi [3];
        longint t;
        kind = $urandom_range(0, 9);
        sc = $urandom_range(2, 23);
        for (int k = 0; k < 3; k++) begin
            lo[k] = longint'($signed(COORD_W'($urandom)));
            hi[k] = longint'($signed(COORD_W'($urandom)));
            if (kind >= 1 && kind <= 2 && lo[k] > hi[k]) begin
                t = lo[k];
                lo[k] = hi[k];
                hi[k] = t;
            end else if (kind >= 3) begin
                centre = longint'(int'($urandom) >>> (31 - sc));
                span = $urandom_range(0, 1 << sc);
                lo[k] = centre - span;
                hi[k] = centre + span;
                if ($urandom_range(0, 7) == 0) begin
                    hi[k] = lo[k];
                end
            end
        end
        return mk_box(clamp_coord(lo[0]), clamp_coord(lo[1]), clamp_coord(lo[2]),
                      clamp_coord(hi[0]), clamp_coord(hi[1]), clamp_coord(hi[2]));
    endfunction

    // Six planes: raw words, a jittered frustum, a frustum with holes, or extremes
    function automatic t_plane_set rand_planes(input t_plane_mix mix);
        t_plane_set s;
        int         co [3];
        int         offs;
        int         dsc;
        dsc = $urandom_range(6, 23);
        for (int p = 0; p < PLANE_COUNT; p++) begin
            case (mix)
                SET_RAW: begin
                    s[p] = {$urandom, $urandom};
                end
                SET_EXTREME: begin
                    s[p] = pack_plane(COEF_PICK[$urandom_range(0, 4)],
                                      COEF_PICK[$urandom_range(0, 4)],
                                      COEF_PICK[$urandom_range(0, 4)],
                                      OFFS_PICK[$urandom_range(0, 3)]);
                end
                default: begin
                    for (int k = 0; k < 3; k++) begin
                        co[k] = int'($urandom_range(0, 510)) - 255;
                    end
                    co[p / 2] = ((p % 2 == 0) ? 1 : -1) * (512 + int'($urandom_range(0, 1023)));
                    offs = $urandom_range(0, 1 << dsc);
                    if (mix == SET_SPARSE) begin
                        if ($urandom_range(0, 2) == 0) begin
                            co[$urandom_range(0, 2)] = 0;
                        end
                        // no normal and a negative offset: must still be skipped
                        if ($urandom_range(0, 2) == 0) begin
                            co = '{0, 0, 0};
                            offs = -offs - 1;
                        end
                    end
                    s[p] = pack_plane(co[0], co[1], co[2], offs);
                end
            endcase
        end
        return s;
    endfunction

    // Setup and access phase of one write; psel stays up for a following write
    task automatic write_plane(input int idx, input logic [PLANE_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(idx << CFG_IDX_LSB);
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
    endtask

    // Write all six planes, then poke the unused slots, which must change nothing
    task automatic load_planes(input t_plane_set s);
        for (int p = 0; p < PLANE_COUNT; p++) begin
            write_plane(p, s[p]);
        end
        write_plane(PLANE_COUNT, {$urandom, $urandom});
        write_plane(PLANE_COUNT + 1, {$urandom, $urandom});
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        plane_sets++;
    endtask

    // Offer one box after a random gap and hold it until accepted
    task automatic send_box(input t_box b);
        int gap;
        gap = $urandom_range(0, tx_idle_max);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        box_drv    <= b;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        boxes_sent++;
    endtask

    // Drop valid and wait until every predicted beat has come back
    task automatic settle();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
        repeat (SETTLE_TAIL) @(posedge i_clk);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Result side: random stalls per beat, one long hold on request
    initial begin
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (hold_req) begin
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end
            rx_gap = $urandom_range(0, rx_idle_max);
            if (rx_gap > 0) begin
                i_out_ready <= 1'b0;
                repeat (rx_gap) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    initial begin
        psel        <= 1'b0;
        penable     <= 1'b0;
        pwrite      <= 1'b0;
        paddr       <= '0;
        pwdata      <= '0;
        i_in_valid  <= 1'b0;
        box_drv     <= '0;
        i_out_ready <= 1'b0;
        i_rst_n     <= 1'b0;
        tx_idle_max = IDLE_MAX;
        rx_idle_max = IDLE_MAX;
        hold_req = 1'b0;
        boxes_sent = 0;
        plane_sets = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset planes: only box validity matters
        send_box(mk_box(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX));
        send_box(mk_box(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX));
        send_box(mk_box(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN));
        send_box(mk_box(1, 0, 0, 0, 0, 0));
        send_box(mk_box(0, 1, 0, 0, 0, 0));
        send_box(mk_box(0, 0, 1, 0, 0, 0));
        send_box(mk_box(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MIN));

        // boundary planes: zero distance stays visible, skipped planes never cull
        settle();
        plane_set[REG_LEFT]   = pack_plane(ONE_Q10, 0, 0, 0);
        plane_set[REG_RIGHT]  = pack_plane(0, 0, 0, -1);
        plane_set[REG_BOTTOM] = pack_plane(0, -ONE_Q10, 0, ONE_Q8);
        plane_set[REG_TOP]    = pack_plane(0, 0, 0, OFFS_MIN);
        plane_set[REG_NEAR]   = pack_plane(0, 0, 1, 0);
        plane_set[REG_FAR]    = pack_plane(0, 0, COEF_MIN, OFFS_MAX);
        load_planes(plane_set);
        send_box(mk_box(-10, 0, 0, 0, 0, 0));
        send_box(mk_box(-10, 0, 0, -1, 0, 0));
        send_box(mk_box(0, ONE_Q8, 0, 5, 300, 0));
        send_box(mk_box(0, ONE_Q8 + 1, 0, 5, 300, 0));
        send_box(mk_box(0, 0, -5, 0, 0, -1));
        send_box(mk_box(COORD_MIN, COORD_MIN, 0, COORD_MAX, COORD_MAX, COORD_MAX));

        // all-ones planes: normal of minus one ulp on every axis
        settle();
        for (int p = 0; p < PLANE_COUNT; p++) begin
            plane_set[p] = '1;
        end
        load_planes(plane_set);
        send_box(mk_box(COORD_MIN, COORD_MIN, COORD_MIN, 0, 0, 0));
        send_box(mk_box(0, 0, 0, 1, 1, 1));
        send_box(mk_box(-ONE_Q10, 0, 0, 0, 0, 0));

        // largest positive normals with the most negative offset
        settle();
        for (int p = 0; p < PLANE_COUNT; p++) begin
            plane_set[p] = pack_plane(COEF_MAX, COEF_MAX, COEF_MAX, OFFS_MIN);
        end
        load_planes(plane_set);
        send_box(mk_box(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX));
        send_box(mk_box(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX));

        // most negative normals with the largest offset
        settle();
        for (int p = 0; p < PLANE_COUNT; p++) begin
            plane_set[p] = pack_plane(COEF_MIN, COEF_MIN, COEF_MIN, OFFS_MAX);
        end
        load_planes(plane_set);
        send_box(mk_box(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX));
        send_box(mk_box(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX));
        directed_sent = boxes_sent;

        // random phases, each under a fresh plane set and its own idling pattern
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            settle();
            load_planes(rand_planes(t_plane_mix'(ph % 4)));
            case (ph)
                0: begin
                    tx_idle_max = 0;
                    rx_idle_max = 0;
                end
                3: begin
                    tx_idle_max = 0;
                    rx_idle_max = IDLE_MAX;
                    hold_req = 1'b1;
                end
                5: begin
                    tx_idle_max = IDLE_MAX;
                    rx_idle_max = 0;
                end
                6: begin
                    tx_idle_max = 0;
                    rx_idle_max = IDLE_MAX;
                end
                default: begin
                    tx_idle_max = IDLE_MAX;
                    rx_idle_max = IDLE_MAX;
                end
            endcase
            repeat (PHASE_BOXES) send_box(rand_box());
        end

        // drain and give the verdict
        settle();
        $display("Sent %0d boxes (%0d directed) under %0d plane settings, %0d judged visible",
                 boxes_sent, directed_sent, plane_sets, visible_beats);
        $display("Both channels idled 0 to %0d cycles per beat; one %0d-cycle output hold",
                 IDLE_MAX, HOLD_CYCLES);
        if (mismatches == 0 && outstanding == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/bfv_pkg.sv
rtl/core/bfv_cfg_regs.sv
rtl/core/bfv_plane_eval.sv
rtl/core/box_frustum_visibility_test.sv
rtl/core/bfv_checker.sv
verif/bfv_visibility_checker.sv
verif/tb_box_frustum_visibility_test.sv
